>>> rtl/nbcs_pkg.sv
// Shared types and constants for the nested block control stack.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package nbcs_pkg;

	// default sizing
	localparam int STACK_DEPTH_DEF = 16;
	localparam int NUM_LINES_DEF   = 2048;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int LINE_W  = 11;
	localparam int DEPTH_W = 5;
	localparam int ERR_W   = 3;

	// depth limit after reset
	localparam logic [DEPTH_W-1:0] LIMIT_RESET = 5'd16;

	// frame kinds
	localparam logic KIND_IF    = 1'b0;
	localparam logic KIND_WHILE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_IF       = 3'd0,
		OP_ELIF     = 3'd1,
		OP_ELSE     = 3'd2,
		OP_ENDIF    = 3'd3,
		OP_WHILE    = 3'd4,
		OP_ENDWHILE = 3'd5,
		OP_PLAIN    = 3'd6
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 3'd0,
		ERR_DEEP     = 3'd1,
		ERR_ELIF     = 3'd2,
		ERR_ELSE     = 3'd3,
		ERR_ENDIF    = 3'd4,
		ERR_ENDWHILE = 3'd5,
		ERR_HALTED   = 3'd6
	} err_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              cond;
		logic [LINE_W-1:0] line_index;
	} item_t;

	typedef struct packed {
		logic               active;
		logic               cond_used;
		logic               jump;
		logic [LINE_W-1:0]  jump_line;
		logic [DEPTH_W-1:0] depth_now;
		logic [ERR_W-1:0]   error_code;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic step;    // item accepted this cycle
		logic halted;  // block is halted after an error
		logic cfg_wr;  // depth limit write
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fault;   // accepted item raised an error
	} ctl_status_t;

endpackage

>>> rtl/nbcs_ctrl.sv
// Controller of the nested block control stack: run/halt state machine,
// handshakes and the command bundle for the datapath. Uses nbcs_pkg.
`timescale 1ns / 1ps

module nbcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	output logic                 busy,
	output nbcs_pkg::ctl_cmd_t   cmd,
	input  nbcs_pkg::ctl_status_t status
);
	import nbcs_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_HALT = 2'b10
	} state_t;

	state_t state_q, state_d;

	// every item finishes in its accept cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign cmd.step   = start & ~busy;
	assign cmd.halted = (state_q == ST_HALT);
	assign cmd.cfg_wr = cfg_valid & cfg_ready;

	// an error halts the block until reset
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (cmd.step && status.fault) state_d = ST_HALT;
			end
			ST_HALT: state_d = ST_HALT;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RUN;
		else         state_q <= state_d;
	end

endmodule

>>> rtl/nbcs_datapath.sv
// Datapath of the nested block control stack: frame storage, depth
// counter, depth limit register, step logic and result register. Uses nbcs_pkg.
`timescale 1ns / 1ps

module nbcs_datapath #(
	parameter int STACK_DEPTH = nbcs_pkg::STACK_DEPTH_DEF,
	parameter int NUM_LINES   = nbcs_pkg::NUM_LINES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nbcs_pkg::ctl_cmd_t          cmd,
	output nbcs_pkg::ctl_status_t       status,
	input  nbcs_pkg::item_t             item,
	input  logic [nbcs_pkg::DEPTH_W-1:0] cfg_data,
	output nbcs_pkg::result_t           result,
	output logic                        done
);
	import nbcs_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	// frame stack; supb marks a frame opened under a suppressed outer block
	logic [STACK_DEPTH-1:0] kind_q, exec_q, taken_q, supb_q;
	logic [LINE_W-1:0]      line_q [STACK_DEPTH];
	logic [CNT_W-1:0]       depth_q, depth_d;
	logic [DEPTH_W-1:0]     limit_q;

	result_t result_q;
	logic    done_q;

	logic [IDX_W-1:0]  top_idx, push_idx, wr_idx;
	logic              has_top, kind_t, exec_t, taken_t, supb_t, outer_push;
	logic [LINE_W-1:0] line_t, line_clamped;
	logic [CNT_W-1:0]  limit_eff;

	err_t              err;
	logic              cond_used, jump, active_c, commit;
	logic [LINE_W-1:0] jline;
	logic              do_push, do_pop, do_upd;
	logic              new_kind, new_exec, new_taken;

	// top of stack read
	assign has_top  = (depth_q != '0);
	assign top_idx  = IDX_W'(depth_q - CNT_W'(1));
	assign push_idx = IDX_W'(depth_q);
	assign kind_t   = kind_q[top_idx];
	assign exec_t   = exec_q[top_idx];
	assign taken_t  = taken_q[top_idx];
	assign supb_t   = supb_q[top_idx];
	assign line_t   = line_q[top_idx];

	// a new frame sees suppression if the current top or anything below is off
	assign outer_push = has_top & (supb_t | ~exec_t);

	// limit clipped to the stack size
	always_comb begin
		if (32'(limit_q) > STACK_DEPTH) limit_eff = CNT_W'(STACK_DEPTH);
		else                            limit_eff = CNT_W'(limit_q);
	end

	// line clamp
	always_comb begin
		if (17'(item.line_index) >= 17'(NUM_LINES)) line_clamped = LINE_W'(NUM_LINES - 1);
		else                                        line_clamped = item.line_index;
	end

	// step decode
	always_comb begin
		err       = ERR_OK;
		cond_used = 1'b0;
		jump      = 1'b0;
		jline     = '0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_upd    = 1'b0;
		new_kind  = KIND_IF;
		new_exec  = exec_t;
		new_taken = taken_t;
		active_c  = ~has_top | ~(supb_t | ~exec_t);
		if (cmd.halted) begin
			err = ERR_HALTED;
		end else begin
			unique case (op_t'(item.op))
				OP_IF, OP_WHILE: begin
					if (depth_q >= limit_eff) begin
						err = ERR_DEEP;
					end else begin
						do_push  = 1'b1;
						new_kind = (op_t'(item.op) == OP_WHILE) ? KIND_WHILE : KIND_IF;
						if (outer_push) begin
							new_exec  = 1'b0;
							new_taken = (op_t'(item.op) == OP_IF);
						end else begin
							cond_used = 1'b1;
							new_exec  = item.cond;
							new_taken = (op_t'(item.op) == OP_IF) & item.cond;
						end
						active_c = ~(outer_push | ~new_exec);
					end
				end
				OP_ELIF, OP_ELSE, OP_ENDIF: begin
					if (!has_top || kind_t != KIND_IF) begin
						if (op_t'(item.op) == OP_ELIF)      err = ERR_ELIF;
						else if (op_t'(item.op) == OP_ELSE) err = ERR_ELSE;
						else                                err = ERR_ENDIF;
					end else if (op_t'(item.op) == OP_ENDIF) begin
						do_pop   = 1'b1;
						active_c = ~supb_t;
					end else begin
						do_upd = 1'b1;
						if (supb_t) begin
							new_exec = 1'b0;
						end else if (op_t'(item.op) == OP_ELSE) begin
							new_exec = ~taken_t;
						end else if (taken_t) begin
							new_exec = 1'b0;
						end else begin
							cond_used = 1'b1;
							new_exec  = item.cond;
							new_taken = taken_t | item.cond;
						end
						active_c = ~(supb_t | ~new_exec);
					end
				end
				OP_ENDWHILE: begin
					if (!has_top || kind_t != KIND_WHILE) begin
						err = ERR_ENDWHILE;
					end else begin
						do_pop   = 1'b1;
						jump     = exec_t;
						jline    = exec_t ? line_t : '0;
						active_c = ~supb_t;
					end
				end
				default: ; // plain statement and the unused code
			endcase
		end
	end

	assign status.fault = cmd.step & ~cmd.halted & (err != ERR_OK);
	assign commit       = cmd.step & ~cmd.halted & (err == ERR_OK);
	assign wr_idx       = do_push ? push_idx : top_idx;

	// depth after the step
	always_comb begin
		depth_d = depth_q;
		if (commit && do_push)     depth_d = depth_q + CNT_W'(1);
		else if (commit && do_pop) depth_d = depth_q - CNT_W'(1);
	end

	// frame writes
	always_ff @(posedge clk) begin
		if (commit && do_push) begin
			kind_q[wr_idx] <= new_kind;
			supb_q[wr_idx] <= outer_push;
			line_q[wr_idx] <= line_clamped;
		end
		if (commit && (do_push || do_upd)) begin
			exec_q[wr_idx]  <= new_exec;
			taken_q[wr_idx] <= new_taken;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			limit_q <= LIMIT_RESET;
			done_q  <= 1'b0;
		end else begin
			depth_q <= depth_d;
			done_q  <= cmd.step;
			if (cmd.cfg_wr) limit_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			result_q.active     <= active_c;
			result_q.cond_used  <= cond_used;
			result_q.jump       <= jump;
			result_q.jump_line  <= jline;
			result_q.depth_now  <= DEPTH_W'(depth_d);
			result_q.error_code <= err;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

>>> rtl/nested_block_control_stack.sv
// Top level of the nested block control stack: controller plus datapath.
// Depends on nbcs_pkg, nbcs_ctrl and nbcs_datapath.
`timescale 1ns / 1ps

// One line event is taken per clock: busy never rises, so an item is
// accepted at every edge where start is high. Its result appears on
// result in the cycle after acceptance, flagged by done for exactly one cycle; the
// receiver cannot stall, so it must sample result whenever done is high.
// The whole step (top-of-stack read, decode, frame write) fits in the
// accept cycle, which sets the rate at one item per cycle. After any
// error the block reports the halted code for every later item until
// reset. The depth limit may be written at any time the block is idle;
// cfg_ready is always high.
module nested_block_control_stack #(
	parameter int STACK_DEPTH = nbcs_pkg::STACK_DEPTH_DEF,
	parameter int NUM_LINES   = nbcs_pkg::NUM_LINES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  nbcs_pkg::item_t              item,
	output logic                         done,
	output nbcs_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [nbcs_pkg::DEPTH_W-1:0] cfg_data
);
	import nbcs_pkg::*;

	ctl_cmd_t    cmd;
	ctl_status_t status;

	nbcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.cmd       (cmd),
		.status    (status)
	);

	nbcs_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.NUM_LINES   (NUM_LINES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.item     (item),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

endmodule

>>> tb/tb.sv
// Testbench for nested_block_control_stack: random nesting of if and while line events.
// A scoreboard class keeps its own frame stack to predict each step.
// Depends on nbcs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import nbcs_pkg::*;

	localparam int STACK_N = STACK_DEPTH_DEF;
	localparam int WATCHDOG_CYCLES = 1000;
	// op code with no meaning; the block treats it as a plain statement
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	// Frame stack predictor plus the queue of step results still due
	class frame_stack_scoreboard;
		bit                frame_kind[STACK_N];
		bit                frame_run[STACK_N];
		bit                frame_taken[STACK_N];
		logic [LINE_W-1:0] frame_start[STACK_N];
		int unsigned       open_frames;
		bit                stuck;
		logic [DEPTH_W-1:0] depth_limit;
		result_t           step_results_due[$];
		int                errors;
		int                items_taken;
		int                results_checked;
		int                deepest;
		int                loop_backs;
		int                fault_code;

		function new();
			open_frames = 0;
			stuck = 0;
			depth_limit = LIMIT_RESET;
			errors = 0;
			items_taken = 0;
			results_checked = 0;
			deepest = 0;
			loop_backs = 0;
			fault_code = 0;
		endfunction

		// 1 if any frame below count is not running
		function bit outer_held(int unsigned count);
			for (int i = 0; i < STACK_N && i < count; i++) begin
				if (!frame_run[i])
					return 1;
			end
			return 0;
		endfunction

		function void write_limit(logic [DEPTH_W-1:0] v);
			depth_limit = v;
		endfunction

		function int pending();
			return step_results_due.size();
		endfunction

		// Work out the result of one accepted line event
		function void take_line_event(item_t it);
			result_t     r;
			logic [OP_W-1:0] op;
			int unsigned lim;
			int unsigned top;
			r = '0;
			op = it.op;
			lim = (depth_limit > STACK_N) ? STACK_N : depth_limit;
			items_taken++;
			if (stuck) begin
				r.error_code = ERR_HALTED;
			end else if (op == OP_IF || op == OP_WHILE) begin
				if (open_frames >= lim) begin
					r.error_code = ERR_DEEP;
				end else begin
					top = open_frames;
					frame_kind[top] = (op == OP_IF) ? KIND_IF : KIND_WHILE;
					frame_start[top] = it.line_index;
					if (outer_held(top)) begin
						frame_run[top] = 0;
						frame_taken[top] = (op == OP_IF);
					end else begin
						r.cond_used = 1'b1;
						frame_run[top] = it.cond;
						frame_taken[top] = (op == OP_IF) ? it.cond : 1'b0;
					end
					open_frames = top + 1;
				end
			end else if (op == OP_ELIF || op == OP_ELSE || op == OP_ENDIF) begin
				if (open_frames == 0 || frame_kind[open_frames-1] != KIND_IF) begin
					r.error_code = (op == OP_ELIF) ? ERR_ELIF :
						(op == OP_ELSE) ? ERR_ELSE : ERR_ENDIF;
				end else begin
					top = open_frames - 1;
					if (op == OP_ENDIF) begin
						open_frames = top;
					end else if (outer_held(top)) begin
						frame_run[top] = 0;
					end else if (op == OP_ELSE) begin
						frame_run[top] = !frame_taken[top];
					end else if (frame_taken[top]) begin
						frame_run[top] = 0;
					end else begin
						r.cond_used = 1'b1;
						frame_run[top] = it.cond;
						if (it.cond)
							frame_taken[top] = 1;
					end
				end
			end else if (op == OP_ENDWHILE) begin
				if (open_frames == 0 || frame_kind[open_frames-1] != KIND_WHILE) begin
					r.error_code = ERR_ENDWHILE;
				end else begin
					top = open_frames - 1;
					if (frame_run[top]) begin
						r.jump = 1'b1;
						r.jump_line = frame_start[top];
						loop_backs++;
					end
					open_frames = top;
				end
			end
			if (r.error_code != ERR_OK) begin
				if (!stuck)
					fault_code = r.error_code;
				stuck = 1;
			end
			r.active = !outer_held(open_frames);
			r.depth_now = DEPTH_W'(open_frames);
			if (open_frames > deepest)
				deepest = open_frames;
			step_results_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [LINE_W-1:0] want,
				logic [LINE_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one strobed result with the oldest prediction
		function void check_step_result(result_t got);
			result_t want;
			if (step_results_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = step_results_due.pop_front();
			results_checked++;
			compare_field("active", LINE_W'(want.active), LINE_W'(got.active));
			compare_field("cond_used", LINE_W'(want.cond_used), LINE_W'(got.cond_used));
			compare_field("jump", LINE_W'(want.jump), LINE_W'(got.jump));
			compare_field("jump_line", want.jump_line, got.jump_line);
			compare_field("depth_now", LINE_W'(want.depth_now), LINE_W'(got.depth_now));
			compare_field("error_code", LINE_W'(want.error_code), LINE_W'(got.error_code));
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	item_t              item = '0;
	logic               done;
	result_t            result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [DEPTH_W-1:0] cfg_data = '0;

	frame_stack_scoreboard stack_sb = new();

	// stimulus-side view of the open frames and the limit
	bit                 open_kinds[$];
	logic [DEPTH_W-1:0] cur_limit = LIMIT_RESET;
	int                 burst_left = 0;
	int                 idle_cycles = 0;

	nested_block_control_stack dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: note accepted items and limit writes, check strobed results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				stack_sb.write_limit(cfg_data);
			if (start && !busy)
				stack_sb.take_line_event(item);
			if (done)
				stack_sb.check_step_result(result);
		end
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Watchdog on cycles with no handshake at all
	initial begin
		wait (idle_cycles >= WATCHDOG_CYCLES);
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int gen_room();
		return (cur_limit > STACK_N) ? STACK_N : cur_limit;
	endfunction

	function automatic logic [LINE_W-1:0] rand_line();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? {LINE_W{1'b1}} : {LINE_W{1'b0}};
		return LINE_W'($urandom_range(0, 2047));
	endfunction

	// Send one item; the sender works in bursts with random gaps between them
	task automatic issue(logic [OP_W-1:0] op, logic c, logic [LINE_W-1:0] ln);
		item_t it;
		int    gap;
		bit    has_if;
		bit    has_while;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		it.op = op;
		it.cond = c;
		it.line_index = ln;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		// track legal frame changes only
		has_if = open_kinds.size() > 0 && open_kinds[$] == KIND_IF;
		has_while = open_kinds.size() > 0 && open_kinds[$] == KIND_WHILE;
		if (op == OP_IF || op == OP_WHILE) begin
			if (open_kinds.size() < gen_room())
				open_kinds.push_back((op == OP_IF) ? KIND_IF : KIND_WHILE);
		end else if ((op == OP_ENDIF && has_if) || (op == OP_ENDWHILE && has_while)) begin
			void'(open_kinds.pop_back());
		end
	endtask

	// Drop start and let every outstanding result come back
	task automatic wait_idle();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (stack_sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(logic [DEPTH_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_limit = v;
	endtask

	// One well-formed event; push_w sets how often a new frame opens
	task automatic random_step(int push_w);
		int    pick;
		bit    room;
		bit    has_if;
		bit    has_while;
		logic [OP_W-1:0] op;
		pick = $urandom_range(0, 99);
		room = open_kinds.size() < gen_room();
		has_if = open_kinds.size() > 0 && open_kinds[$] == KIND_IF;
		has_while = open_kinds.size() > 0 && open_kinds[$] == KIND_WHILE;
		if (pick < push_w && room) begin
			op = $urandom_range(0, 1) ? OP_IF : OP_WHILE;
		end else if (pick < push_w + 40 && has_if) begin
			case ($urandom_range(0, 3))
				0: op = OP_ELIF;
				1: op = OP_ELSE;
				default: op = OP_ENDIF;
			endcase
		end else if (pick < push_w + 40 && has_while) begin
			op = OP_ENDWHILE;
		end else begin
			op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_PLAIN;
		end
		issue(op, 1'($urandom_range(0, 1)), rand_line());
	endtask

	task automatic run_phase(logic [DEPTH_W-1:0] lim, int count, int push_w);
		wait_idle();
		write_limit(lim);
		repeat (count) random_step(push_w);
	endtask

	task automatic close_all();
		while (open_kinds.size() > 0)
			issue((open_kinds[$] == KIND_IF) ? OP_ENDIF : OP_ENDWHILE,
				1'($urandom_range(0, 1)), rand_line());
	endtask

	// Provoke one error of a random kind, then run a few items while halted
	task automatic trip_fault();
		int kind;
		kind = $urandom_range(1, 5);
		if (kind == 1) begin
			wait_idle();
			write_limit(DEPTH_W'(open_kinds.size()));
			issue($urandom_range(0, 1) ? OP_IF : OP_WHILE, 1'($urandom_range(0, 1)), rand_line());
		end else begin
			close_all();
			// closer of the wrong kind on top, or nothing open at all
			if ($urandom_range(0, 1))
				issue((kind == 5) ? OP_IF : OP_WHILE, 1'($urandom_range(0, 1)), rand_line());
			case (kind)
				2: issue(OP_ELIF, 1'($urandom_range(0, 1)), rand_line());
				3: issue(OP_ELSE, 1'($urandom_range(0, 1)), rand_line());
				4: issue(OP_ENDIF, 1'($urandom_range(0, 1)), rand_line());
				default: issue(OP_ENDWHILE, 1'($urandom_range(0, 1)), rand_line());
			endcase
		end
		repeat (6)
			issue(OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand_line());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain and unused codes at the outer level
		issue(OP_PLAIN, 1'b1, 11'd0);
		issue(OP_UNUSED, 1'b0, 11'd2047);
		// if taken at once: later elif and else are skipped
		issue(OP_IF, 1'b1, 11'd0);
		issue(OP_ELIF, 1'b1, 11'd1);
		issue(OP_ELSE, 1'b0, 11'd2);
		issue(OP_ENDIF, 1'b0, 11'd3);
		// second elif taken
		issue(OP_IF, 1'b0, 11'd2047);
		issue(OP_ELIF, 1'b0, 11'd2046);
		issue(OP_ELIF, 1'b1, 11'd1024);
		issue(OP_ELSE, 1'b1, 11'd1025);
		issue(OP_ENDIF, 1'b1, 11'd1026);
		// else runs when nothing was taken
		issue(OP_IF, 1'b0, 11'd10);
		issue(OP_ELSE, 1'b0, 11'd11);
		issue(OP_ENDIF, 1'b0, 11'd12);
		// running loop jumps back to its start line
		issue(OP_WHILE, 1'b1, 11'd2047);
		issue(OP_PLAIN, 1'b0, 11'd1365);
		issue(OP_ENDWHILE, 1'b0, 11'd682);
		// everything inside a suppressed loop is suppressed
		issue(OP_WHILE, 1'b0, 11'd5);
		issue(OP_IF, 1'b1, 11'd6);
		issue(OP_ELIF, 1'b1, 11'd7);
		issue(OP_ELSE, 1'b1, 11'd8);
		issue(OP_ENDIF, 1'b1, 11'd9);
		issue(OP_WHILE, 1'b1, 11'd10);
		issue(OP_ENDWHILE, 1'b1, 11'd11);
		issue(OP_ENDWHILE, 1'b1, 11'd12);

		// random phases over several depth limits, extremes included
		run_phase(5'd31, 180, 60);
		run_phase(5'd1, 150, 40);
		run_phase(5'd0, 60, 30);
		run_phase(5'd16, 200, 65);
		run_phase(DEPTH_W'($urandom_range(2, 15)), 200, 45);
		run_phase(5'd16, 300, 35);
		run_phase(DEPTH_W'($urandom_range(17, 31)), 200, 50);
		trip_fault();

		wait_idle();
		repeat (4) @(posedge clk);
		$display("Ran %0d line events, checked %0d results, nesting reached depth %0d",
			stack_sb.items_taken, stack_sb.results_checked, stack_sb.deepest);
		$display("Saw %0d loop-back jumps; the run ended halted on error code %0d",
			stack_sb.loop_backs, stack_sb.fault_code);
		if (stack_sb.errors == 0 && stack_sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
rtl/nbcs_pkg.sv
rtl/nbcs_ctrl.sv
rtl/nbcs_datapath.sv
rtl/nested_block_control_stack.sv
tb/tb.sv
